[sv/moving_average_cubic_linearizer_core_assert.svh]
// Assertion macros for the moving average linearizer controller
`ifndef MOVING_AVERAGE_CUBIC_LINEARIZER_CORE_ASSERT_SVH
`define MOVING_AVERAGE_CUBIC_LINEARIZER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MACL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("macl: implication check failed");
// next-cycle implication
`define MACL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("macl: next-cycle check failed");
`else
`define MACL_ASSERT_IMP(lbl, ante, cons)
`define MACL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[sv/macl_pkg.sv]
// Shared constants and types for the moving average cubic linearizer
package macl_pkg;

	// averaging window
	localparam int WINDOW = 16;
	localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SMP_W  = 10;
	localparam int SUM_W  = SMP_W + $clog2(WINDOW);

	// fixed point curve
	localparam int COEF_W = 48;
	localparam int FRAC_W = 32;
	localparam int MUL_W  = 51;   // clamped accumulator fits here
	localparam int ACC_W  = 62;   // full product width
	localparam int OUT_W  = 10;

	// register indexes
	localparam logic [1:0] REG_CUBIC  = 2'd0;
	localparam logic [1:0] REG_SQUARE = 2'd1;
	localparam logic [1:0] REG_LINEAR = 2'd2;
	localparam logic [1:0] REG_OFFSET = 2'd3;

	// coefficient reset values
	localparam logic signed [COEF_W-1:0] RST_CUBIC  = -48'sd3865;
	localparam logic signed [COEF_W-1:0] RST_SQUARE = 48'sd6442451;
	localparam logic signed [COEF_W-1:0] RST_LINEAR = -48'sd3954805886;
	localparam logic signed [COEF_W-1:0] RST_OFFSET = 48'sd976372915400;

	// Horner step sequencing
	localparam logic [1:0] LAST_STEP = 2'd2;

	typedef enum logic [1:0] {
		SEL_SQUARE = 2'd0,
		SEL_LINEAR = 2'd1,
		SEL_OFFSET = 2'd2
	} coef_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic      load;    // take a new sample, update ring and sum
		logic      step;    // one Horner multiply-add
		coef_sel_t sel;     // coefficient added in this step
		logic      clamp;   // bound the accumulator after this step
		logic      finish;  // scale, saturate and load the output register
	} macl_cmd_t;

endpackage

[sv/macl_ctrl.sv]
// Controller: request handshakes and Horner step sequencing
`include "moving_average_cubic_linearizer_core_assert.svh"

module macl_ctrl
	import macl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output macl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_STEP = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] cnt_q;
	logic       out_valid_q;
	logic       can_fin;
	logic       accept;

	// output register free or being emptied this cycle
	assign can_fin  = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) || ((state_q == ST_FIN) && can_fin));
	assign accept   = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		cmd.step   = (state_q == ST_STEP);
		cmd.finish = (state_q == ST_FIN) && can_fin;
		unique case (cnt_q)
			2'd0: cmd.sel = SEL_SQUARE;
			2'd1: cmd.sel = SEL_LINEAR;
			default: cmd.sel = SEL_OFFSET;
		endcase
		cmd.clamp = (cnt_q != LAST_STEP);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_STEP;
			end
			ST_STEP: begin
				if (cnt_q == LAST_STEP) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (can_fin) state_d = accept ? ST_STEP : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				cnt_q <= '0;
			else if (cmd.step)
				cnt_q <= cnt_q + 2'd1;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	`MACL_ASSERT_NXT(a_accept_starts, accept, (state_q == ST_STEP) && (cnt_q == 2'd0))
	`MACL_ASSERT_NXT(a_last_step_fin, (state_q == ST_STEP) && (cnt_q == LAST_STEP), state_q == ST_FIN)
	`MACL_ASSERT_NXT(a_finish_valid, cmd.finish, out_valid_q)

endmodule

[sv/macl_dpath.sv]
// Datapath: sample ring, running sum, shared Horner multiplier and output register
module macl_dpath
	import macl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  macl_cmd_t                cmd,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [COEF_W-1:0]        cfg_wdata,
	input  logic [SMP_W-1:0]         sample,
	output logic [SMP_W-1:0]         mean,
	output logic signed [OUT_W-1:0]  distance
);

	localparam logic signed [ACC_W:0] ACC_LIMIT = (ACC_W+1)'(64'sd1 <<< 49);
	localparam logic signed [ACC_W-FRAC_W-1:0] Q_MAX = (ACC_W-FRAC_W)'(511);
	localparam logic signed [ACC_W-FRAC_W-1:0] Q_MIN = -(ACC_W-FRAC_W)'(512);

	logic [SMP_W-1:0]         ring_q [WINDOW];
	logic [IDX_W-1:0]         idx_q;
	logic [SUM_W-1:0]         sum_q;
	logic signed [COEF_W-1:0] c3_q, c2_q, c1_q, c0_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [SMP_W-1:0]         mean_q;
	logic signed [OUT_W-1:0]  dist_q;

	logic [SMP_W-1:0]               mean_c;
	logic signed [MUL_W-1:0]        mul_a;
	logic signed [SMP_W:0]          mul_b;
	logic signed [ACC_W-1:0]        prod_c;
	logic signed [COEF_W-1:0]       coef_c;
	logic signed [ACC_W:0]          sum_c;
	logic signed [ACC_W-1:0]        acc_d;
	logic signed [ACC_W-FRAC_W-1:0] q_c;
	logic signed [OUT_W-1:0]        dist_c;

	// truncated mean of the window
	assign mean_c = SMP_W'(sum_q / SUM_W'(WINDOW));

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c3_q <= RST_CUBIC;
			c2_q <= RST_SQUARE;
			c1_q <= RST_LINEAR;
			c0_q <= RST_OFFSET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CUBIC:  c3_q <= cfg_wdata;
				REG_SQUARE: c2_q <= cfg_wdata;
				REG_LINEAR: c1_q <= cfg_wdata;
				REG_OFFSET: c0_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sample ring, running sum and write index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) ring_q[i] <= '0;
			idx_q <= '0;
			sum_q <= '0;
		end else if (cmd.load) begin
			ring_q[idx_q] <= sample;
			sum_q <= sum_q - SUM_W'(ring_q[idx_q]) + SUM_W'(sample);
			idx_q <= (idx_q == IDX_W'(WINDOW - 1)) ? '0 : idx_q + IDX_W'(1);
		end
	end

	// one Horner multiply-add per step
	always_comb begin
		unique case (cmd.sel)
			SEL_SQUARE: coef_c = c2_q;
			SEL_LINEAR: coef_c = c1_q;
			SEL_OFFSET: coef_c = c0_q;
			default:    coef_c = c0_q;
		endcase
		mul_a  = acc_q[MUL_W-1:0];
		mul_b  = signed'({1'b0, mean_c});
		prod_c = mul_a * mul_b;
		sum_c  = (ACC_W+1)'(prod_c) + (ACC_W+1)'(coef_c);
		// bound the intermediate so it stays within the multiplier input
		priority if (cmd.clamp && (sum_c > ACC_LIMIT))
			acc_d = ACC_W'(ACC_LIMIT);
		else if (cmd.clamp && (sum_c < -ACC_LIMIT))
			acc_d = ACC_W'(-ACC_LIMIT);
		else
			acc_d = ACC_W'(sum_c);
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			acc_q <= ACC_W'(c3_q);
		else if (cmd.step)
			acc_q <= acc_d;
	end

	// divide by 2^32 toward zero, then saturate
	always_comb begin
		q_c = acc_q[ACC_W-1:FRAC_W] + (ACC_W-FRAC_W)'(acc_q[ACC_W-1] && (|acc_q[FRAC_W-1:0]));
		priority if (q_c > Q_MAX)
			dist_c = OUT_W'(Q_MAX);
		else if (q_c < Q_MIN)
			dist_c = OUT_W'(Q_MIN);
		else
			dist_c = q_c[OUT_W-1:0];
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			mean_q <= mean_c;
			dist_q <= dist_c;
		end
	end

	assign mean     = mean_q;
	assign distance = dist_q;

endmodule

[sv/moving_average_cubic_linearizer_core.sv]
// A request is accepted, the Horner steps run in ST_STEP, and ST_FIN loads the result into
// the output register once it is free; the shared multiplier does one Horner step a cycle.
// A new request is taken in the cycle the previous result enters the output register.
// Reset (arst_n low): sample ring, running sum and write index cleared, coefficients
// return to their defaults, no result pending; no clearing pass is needed.
module moving_average_cubic_linearizer_core
	import macl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [SMP_W-1:0]         sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [SMP_W-1:0]         mean,
	output logic signed [OUT_W-1:0]  distance,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [COEF_W-1:0]        cfg_wdata
);

	macl_cmd_t cmd;

	// handshakes and sequencing
	macl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// averaging and curve evaluation
	macl_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (sample),
		.mean      (mean),
		.distance  (distance)
	);

endmodule

[tb/sv/moving_average_cubic_linearizer_core_tb.sv]
// Self-checking testbench for the moving average cubic linearizer core
`timescale 1ns / 100ps

module moving_average_cubic_linearizer_core_tb;
	import macl_pkg::*;

	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     HOLD_OFF_LEN   = 300;
	localparam longint ACC_BOUND      = longint'(1) << 49;

	localparam logic signed [COEF_W-1:0] COEF_MAX      = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [COEF_W-1:0] COEF_MIN      = 48'sh8000_0000_0000;
	localparam logic signed [COEF_W-1:0] COEF_ZERO     = '0;
	localparam logic signed [COEF_W-1:0] Q32_MINUS_HALF = -48'sd2147483648;
	localparam logic signed [COEF_W-1:0] Q32_MINUS_1P5  = -48'sd6442450944;
	localparam logic signed [COEF_W-1:0] Q32_PLUS_1P5   = 48'sd6442450944;

	typedef struct {
		logic [SMP_W-1:0]        mean;
		logic signed [OUT_W-1:0] distance;
	} reading_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [SMP_W-1:0]        sample;
	logic                    out_valid;
	logic                    out_stall;
	logic [SMP_W-1:0]        mean;
	logic signed [OUT_W-1:0] distance;
	logic                    cfg_we;
	logic [1:0]              cfg_index;
	logic [COEF_W-1:0]       cfg_wdata;

	// predictor state: window ring, running sum, write slot and curve coefficients
	logic [SMP_W-1:0]         avg_ring [WINDOW];
	logic [SUM_W-1:0]         avg_sum;
	int                       avg_slot;
	logic signed [COEF_W-1:0] coef [4];

	reading_t pending_readings [$];
	int       mismatches = 0;
	int       send_idle_pct = 0;
	int       stall_pct = 0;
	int       hold_len = 0;
	int       sample_level = 512;
	int       quiet_cycles = 0;

	wire in_fire  = in_valid && !in_stall;
	wire out_fire = out_valid && !out_stall;

	moving_average_cubic_linearizer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.mean      (mean),
		.distance  (distance),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint bound_acc(input longint a);
		if (a > ACC_BOUND) return ACC_BOUND;
		if (a < -ACC_BOUND) return -ACC_BOUND;
		return a;
	endfunction

	// window update, then the cubic curve in Horner form on the truncated mean
	function automatic reading_t predict_reading(input logic [SMP_W-1:0] s);
		reading_t r;
		longint   m;
		longint   acc;
		longint   q;
		avg_sum = avg_sum - avg_ring[avg_slot] + s;
		avg_ring[avg_slot] = s;
		avg_slot = (avg_slot == WINDOW - 1) ? 0 : avg_slot + 1;
		r.mean = SMP_W'(avg_sum / WINDOW);
		m = longint'(r.mean);
		acc = bound_acc(longint'(coef[REG_CUBIC]));
		acc = bound_acc(acc * m + longint'(coef[REG_SQUARE]));
		acc = bound_acc(acc * m + longint'(coef[REG_LINEAR]));
		acc = acc * m + longint'(coef[REG_OFFSET]);
		// signed division truncates toward zero
		q = acc / (longint'(1) << FRAC_W);
		if (q > 511) q = 511;
		if (q < -512) q = -512;
		r.distance = q[OUT_W-1:0];
		return r;
	endfunction

	function automatic void reset_predictor();
		foreach (avg_ring[i]) avg_ring[i] = '0;
		avg_sum = '0;
		avg_slot = 0;
		coef[REG_CUBIC]  = RST_CUBIC;
		coef[REG_SQUARE] = RST_SQUARE;
		coef[REG_LINEAR] = RST_LINEAR;
		coef[REG_OFFSET] = RST_OFFSET;
	endfunction

	// random signed coefficient with the given number of significant bits
	function automatic logic signed [COEF_W-1:0] rand_coef(input int bits);
		longint v;
		v = longint'({$urandom(), $urandom()});
		v = v >>> (64 - bits);
		return v[COEF_W-1:0];
	endfunction

	// mostly uniform readings, some clustered around a drifting level
	function automatic logic [SMP_W-1:0] pick_sample();
		int v;
		if ($urandom_range(0, 9) < 7) return SMP_W'($urandom_range(0, 1023));
		v = sample_level + int'($urandom_range(0, 30)) - 15;
		if (v < 0) v = 0;
		if (v > 1023) v = 1023;
		return SMP_W'(v);
	endfunction

	// one request; in_valid is left high, the caller either sends again or drops it
	task automatic send_sample(input logic [SMP_W-1:0] s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_readings.push_back(predict_reading(s));
	endtask

	task automatic wait_results_drained();
		while (pending_readings.size() != 0) @(posedge clk);
	endtask

	// write enable stays high across consecutive writes
	task automatic write_reg(input logic [1:0] idx, input logic signed [COEF_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		coef[idx] = val;
	endtask

	task automatic set_coefs(input logic signed [COEF_W-1:0] c3, input logic signed [COEF_W-1:0] c2,
			input logic signed [COEF_W-1:0] c1, input logic signed [COEF_W-1:0] c0);
		write_reg(REG_CUBIC, c3);
		write_reg(REG_SQUARE, c2);
		write_reg(REG_LINEAR, c1);
		write_reg(REG_OFFSET, c0);
		cfg_we <= 1'b0;
	endtask

	task automatic curve_burst(input logic signed [COEF_W-1:0] c3, input logic signed [COEF_W-1:0] c2,
			input logic signed [COEF_W-1:0] c1, input logic signed [COEF_W-1:0] c0,
			input logic [SMP_W-1:0] s);
		set_coefs(c3, c2, c1, c0);
		send_sample(s);
		in_valid <= 1'b0;
		wait_results_drained();
	endtask

	// default curve: fill the window at full scale, then start emptying it
	task automatic test_window_fill();
		int i;
		send_idle_pct = 0;
		stall_pct = 0;
		for (i = 0; i < WINDOW; i++) send_sample(10'd1023);
		for (i = 0; i < 3; i++) send_sample(10'd0);
		in_valid <= 1'b0;
		wait_results_drained();
	endtask

	// saturation both ways, clamped Horner steps, truncation toward zero
	task automatic test_curve_extremes();
		curve_burst(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 10'd1023);
		curve_burst(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 10'd1023);
		curve_burst(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, 10'd0);
		curve_burst(COEF_ZERO, COEF_ZERO, COEF_ZERO, Q32_MINUS_HALF, 10'd512);
		curve_burst(COEF_ZERO, COEF_ZERO, COEF_ZERO, Q32_MINUS_1P5, 10'd1);
		curve_burst(COEF_ZERO, COEF_ZERO, COEF_ZERO, Q32_PLUS_1P5, 10'd700);
	endtask

	// receiver holds off while requests keep coming, so the core fills and stalls
	task automatic test_backpressure();
		int i;
		send_idle_pct = 0;
		stall_pct = 0;
		set_coefs(RST_CUBIC, RST_SQUARE, RST_LINEAR, RST_OFFSET);
		hold_len = HOLD_OFF_LEN;
		for (i = 0; i < 60; i++) send_sample(pick_sample());
		in_valid <= 1'b0;
		wait_results_drained();
	endtask

	// realistic curve for the first half, wider random coefficients for the rest
	task automatic test_random_traffic(input int send_pct, input int stall_pct_in, input int count);
		int i;
		send_idle_pct = send_pct;
		stall_pct = stall_pct_in;
		set_coefs(rand_coef(14), rand_coef(25), rand_coef(34), rand_coef(42));
		for (i = 0; i < count; i++) begin
			if (i % 50 == 0) sample_level = $urandom_range(0, 1023);
			if (i == count / 2) begin
				in_valid <= 1'b0;
				wait_results_drained();
				set_coefs(rand_coef($urandom_range(2, 48)), rand_coef($urandom_range(2, 48)),
					rand_coef($urandom_range(2, 48)), rand_coef($urandom_range(2, 48)));
			end
			send_sample(pick_sample());
		end
		in_valid <= 1'b0;
		wait_results_drained();
	endtask

	// receiver: random stalls, or a long hold-off when one is asked for
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				repeat (n) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// compare each delivered result with the oldest prediction
	always @(posedge clk) begin
		reading_t exp_r;
		if (arst_n && out_fire) begin
			if (pending_readings.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, mean %0d distance %0d", $time, mean, distance);
			end else begin
				exp_r = pending_readings.pop_front();
				if (mean !== exp_r.mean) begin
					mismatches++;
					$display("%0t: mean mismatch, expected %0d, got %0d", $time, exp_r.mean, mean);
				end
				if (distance !== exp_r.distance) begin
					mismatches++;
					$display("%0t: distance mismatch, expected %0d, got %0d",
						$time, exp_r.distance, distance);
				end
			end
		end
	end

	// watchdog on cycles with no request taken on either side
	always @(posedge clk) begin
		if (!arst_n || in_fire || out_fire)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = REG_CUBIC;
		cfg_wdata = '0;
		reset_predictor();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_window_fill();
		test_curve_extremes();
		test_backpressure();
		test_random_traffic(0, 0, 450);
		test_random_traffic(49, 0, 450);
		test_random_traffic(0, 49, 450);
		test_random_traffic(33, 33, 450);

		wait_results_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
